[rtl/apse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package apse_pkg;

  localparam int unsigned WinDepth = 5;
  localparam int unsigned FillW    = 3;

  localparam logic [4:0] H264SpsType = 5'd7;
  localparam logic [4:0] H264PpsType = 5'd8;
  localparam logic [5:0] H265PsFirst = 6'd32;
  localparam logic [5:0] H265PsLast  = 6'd34;

  typedef enum logic [1:0] {
    PhaseSeek    = 2'd0,
    PhaseConfig  = 2'd1,
    PhaseStopped = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } apse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_done;
    logic       config_cached;
  } apse_out_t;

  typedef struct packed {
    logic [WinDepth-1:0][7:0] bytes;
    logic [FillW-1:0]         count;
    logic                     marker;
    logic                     cached_byte;
    logic                     cached_marker;
  } apse_batch_t;

endpackage
`default_nettype wire

[rtl/apse_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
module apse_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire apse_pkg::apse_in_t in_data_i,
  input  wire logic              advance_i,
  output logic                   item_valid_o,
  output apse_pkg::apse_in_t     item_o
);
  import apse_pkg::*;

  logic     vld_q;
  apse_in_t data_q;

  assign in_stall_o   = vld_q & ~advance_i;
  assign item_valid_o = vld_q;
  assign item_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

[rtl/apse_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
module apse_scan (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire apse_pkg::apse_in_t item_i,
  input  wire logic               advance_i,
  input  wire logic               codec_mode_i,
  output apse_pkg::apse_batch_t   batch_o
);
  import apse_pkg::*;

  logic [WinDepth-1:0][7:0] win_q, win_d, wn;
  logic [FillW-1:0]         fill_q, fill_d, f1, keep, e;
  phase_e                   phase_q, phase_d;
  logic                     emit_q, emit_d, cache_q, cache_d;
  logic                     found, sc, s, param, active, in_cfg, eof, cache_new;
  logic [7:0]               b;
  logic [5:0]               t265;

  always_comb begin
    b   = item_i.data_byte;
    eof = item_i.end_of_frame;
    for (int i = 0; i < WinDepth; i++) begin
      wn[i] = (fill_q == FillW'(i)) ? b : win_q[i];
    end
    f1 = fill_q + FillW'(1);

    // start code followed by this header byte
    found = 1'b0;
    sc    = 1'b0;
    if (f1 == FillW'(4)) begin
      found = (wn[0] == 8'd0) && (wn[1] == 8'd0) && (wn[2] == 8'd1);
    end else if (f1 == FillW'(5)) begin
      found = (wn[1] == 8'd0) && (wn[2] == 8'd0) && (wn[3] == 8'd1);
      sc    = (wn[2'd0] != 8'd0);
    end

    // trailing start code at frame end is dropped
    keep = f1;
    if (f1 == FillW'(5)) begin
      if ((wn[2] == 8'd0) && (wn[3] == 8'd0) && (wn[4] == 8'd1)) begin
        keep = (wn[1] == 8'd0) ? FillW'(1) : FillW'(2);
      end
    end else if (f1 == FillW'(4)) begin
      if ((wn[1] == 8'd0) && (wn[2] == 8'd0) && (wn[3] == 8'd1)) begin
        keep = (wn[0] == 8'd0) ? FillW'(0) : FillW'(1);
      end
    end else if (f1 == FillW'(3)) begin
      if ((wn[0] == 8'd0) && (wn[1] == 8'd0) && (wn[2] == 8'd1)) begin
        keep = FillW'(0);
      end
    end

    t265 = b[6:1];
    if (codec_mode_i) begin
      param = (t265 >= H265PsFirst) && (t265 <= H265PsLast);
    end else begin
      param = (b[4:0] == H264SpsType) || (b[4:0] == H264PpsType);
    end

    active = ~cache_q && ((phase_q == PhaseSeek) || (phase_q == PhaseConfig));
    in_cfg = (phase_q == PhaseConfig);

    s = 1'b0;
    e = '0;
    if (active) begin
      if (found) begin
        if (in_cfg) begin
          e = param ? f1 : FillW'(sc);
        end else if (param) begin
          s = sc;
          e = f1;
        end
      end else if (f1 == FillW'(5)) begin
        if (in_cfg) begin
          e = eof ? keep : FillW'(1);
        end
      end else if (in_cfg && eof) begin
        e = keep;
      end
    end

    emit_d    = emit_q | (active & found & param);
    cache_new = cache_q | emit_d;

    for (int j = 0; j < WinDepth; j++) begin
      if (!s) begin
        batch_o.bytes[j] = wn[j];
      end else if (j < WinDepth - 1) begin
        batch_o.bytes[j] = wn[j+1];
      end else begin
        batch_o.bytes[j] = 8'd0;
      end
    end
    batch_o.count         = e - FillW'(s);
    batch_o.marker        = eof;
    batch_o.cached_byte   = cache_q;
    batch_o.cached_marker = cache_new;

    win_d   = win_q;
    fill_d  = fill_q;
    phase_d = phase_q;
    cache_d = cache_q;
    if (active) begin
      if (found) begin
        win_d   = wn;
        fill_d  = '0;
        phase_d = param ? PhaseConfig : PhaseStopped;
      end else if (f1 == FillW'(5)) begin
        for (int k = 0; k < WinDepth - 1; k++) begin
          win_d[k] = wn[k+1];
        end
        win_d[WinDepth-1] = wn[WinDepth-1];
        fill_d = FillW'(WinDepth - 1);
      end else begin
        win_d  = wn;
        fill_d = f1;
      end
    end
    if (eof) begin
      win_d   = '0;
      fill_d  = '0;
      phase_d = PhaseSeek;
      emit_d  = 1'b0;
      cache_d = cache_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      phase_q <= PhaseSeek;
      emit_q  <= 1'b0;
      cache_q <= 1'b0;
    end else if (advance_i) begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      emit_q  <= emit_d;
      cache_q <= cache_d;
    end
  end

endmodule
`default_nettype wire

[rtl/apse_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
module apse_out_buf (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire apse_pkg::apse_batch_t batch_i,
  input  wire logic                  load_i,
  output logic                       can_load_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output apse_pkg::apse_out_t        out_data_o
);
  import apse_pkg::*;

  logic [WinDepth-1:0][7:0] rb_q, rb_d;
  logic [FillW-1:0]         rn_q, rn_d;
  logic                     rm_q, rm_d;
  logic                     rcb_q, rcm_q;
  logic                     pop, last;

  assign out_valid_o = (rn_q != '0) | rm_q;
  assign pop         = out_valid_o & ~out_stall_i;
  assign last        = ((rn_q == FillW'(1)) && !rm_q) || ((rn_q == '0) && rm_q);
  assign can_load_o  = !out_valid_o || (pop && last);

  always_comb begin
    if (rn_q != '0) begin
      out_data_o = '{out_byte: rb_q[0], byte_valid: 1'b1, frame_done: 1'b0,
                     config_cached: rcb_q};
    end else begin
      out_data_o = '{out_byte: 8'd0, byte_valid: 1'b0, frame_done: 1'b1,
                     config_cached: rcm_q};
    end
  end

  always_comb begin
    rb_d = rb_q;
    rn_d = rn_q;
    rm_d = rm_q;
    if (pop) begin
      if (rn_q != '0) begin
        for (int j = 0; j < WinDepth - 1; j++) begin
          rb_d[j] = rb_q[j+1];
        end
        rb_d[WinDepth-1] = 8'd0;
        rn_d = rn_q - FillW'(1);
      end else begin
        rm_d = 1'b0;
      end
    end
    if (load_i) begin
      rb_d = batch_i.bytes;
      rn_d = batch_i.count;
      rm_d = batch_i.marker;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_q <= '0;
      rm_q <= 1'b0;
    end else begin
      rn_q <= rn_d;
      rm_q <= rm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rb_q <= rb_d;
    if (load_i) begin
      rcb_q <= batch_i.cached_byte;
      rcm_q <= batch_i.cached_marker;
    end
  end

endmodule
`default_nettype wire

[rtl/annexb_parameter_set_extractor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Annex B parameter-set extractor. One byte of a coded frame is taken per request, with
// end_of_frame on the frame's last byte. Leading SPS/PPS (H.264) or VPS/SPS/PPS (H.265)
// NALs, start codes included, come out one byte per result request, followed by one end
// marker per frame; codec_mode picks the header rules and may only be written while the
// block is idle. A byte passes the input register, then the combinational scan step into
// the result buffer. One input byte is taken every cycle as long as each byte yields at
// most one result and the output is not stalled; a byte that yields several results
// holds the result buffer until they are all read, and the input stalls until the buffer is
// down to its last pending result. Once a frame has yielded configuration bytes, later
// frames give only the end marker.
module annexb_parameter_set_extractor_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire apse_pkg::apse_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output apse_pkg::apse_out_t     out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i
);
  import apse_pkg::*;

  logic        codec_mode_q;
  logic        item_valid, can_load, advance;
  apse_in_t    item;
  apse_batch_t batch;

  assign cfg_ready_o = 1'b1;
  assign advance     = item_valid & can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      codec_mode_q <= cfg_data_i;
    end
  end

  apse_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  apse_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .advance_i   (advance),
    .codec_mode_i(codec_mode_q),
    .batch_o     (batch)
  );

  apse_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .batch_i    (batch),
    .load_i     (advance),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // a result is either a data byte or the end marker
  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_valid ^ out_data_o.frame_done))
    else $error("result is neither a pure byte nor a pure marker");

  // data bytes only come from frames before the cache flag was set
  a_bytes_uncached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_valid) |-> !out_data_o.config_cached)
    else $error("data byte issued with cache flag set");

  // the scan never overwrites a result that is still stalled at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !(out_valid_o && out_stall_i))
    else $error("scan step loaded over a stalled result");

  // an accepted input byte always reaches the scan on the next cycle
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> item_valid)
    else $error("accepted input byte lost");

endmodule
`default_nettype wire
